>>> design/ksct_pkg.sv
// types and constants shared by the keyed site counter table
`default_nettype none
package ksct_pkg;
  localparam logic [63:0] HASH_MUL = 64'hff51afd7ed558ccd;
  localparam int HASH_SHIFT = 33;
  localparam int TID_SHIFT = 32;
  localparam int KIND_SHIFT = 56;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_CLAIMED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [63:0] caller_address;
    logic [31:0] thread_id;
    logic        alloc_kind;
    logic [63:0] byte_count;
  } ksct_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_index;
    logic [7:0]  probes_taken;
    logic [63:0] entry_calls;
    logic [63:0] entry_bytes;
    logic [63:0] all_calls;
    logic [63:0] all_bytes;
    logic [63:0] spill_calls;
    logic [63:0] spill_bytes;
  } ksct_out_t;
endpackage
`default_nettype wire

>>> design/keyed_site_counter_table.sv
// keyed site counter table: hashed call-site counters with linear probing
//
// in_*   : one event transaction (key plus byte count), accepted when in_valid
//          is high and in_stall low. the block holds in_stall high while busy.
// out_*  : one result transaction per event, held until out_stall is low.
// cfg_*  : write of counting_disabled, taken when cfg_valid and cfg_ready.
// flow   : the hash uses one 32x32 multiplier, adding up its partial
//          products in S_MUL, then probing reads one slot at a time from the
//          slot memory; each probe is a read (S_RD) and a compare (S_CMP).
//          a hit or free slot then goes through S_WR, an overflow after
//          min(PROBE_LIMIT, TABLE_SLOTS) probes through S_OVF, and a disabled
//          event only through S_DIS, before the result is held in S_OUT.
// reset  : synchronous rst_n clears totals and the register; a clearing pass
//          then sweeps the valid bits of all slots, during which no event is
//          accepted (configuration writes are still taken).
// stall  : a result waits in the output register; the next event is taken
//          once the result has been delivered.
`default_nettype none
module keyed_site_counter_table #(
  parameter int TABLE_SLOTS = 4096,
  parameter int PROBE_LIMIT = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ksct_pkg::ksct_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ksct_pkg::ksct_out_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);
  import ksct_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int EFF = (PROBE_LIMIT < TABLE_SLOTS) ? PROBE_LIMIT : TABLE_SLOTS;
  localparam int PW = $clog2(EFF + 1);
  localparam logic [PW-1:0] EFF_P = PW'(EFF);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_HASH  = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_CMP   = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_OVF   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_DIS   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic dis_r;
  ksct_in_t in_r;
  logic [63:0] hx_r, prod_r;
  logic [1:0] mstep_r;
  logic [AW-1:0] slot_r, clr_r;
  logic [PW-1:0] probe_r;
  logic [63:0] gcalls_r, gbytes_r, ocalls_r, obytes_r;
  ksct_out_t out_r;
  logic ovalid_r;

  logic          mem_valid [TABLE_SLOTS];
  logic [96:0]   mem_key [TABLE_SLOTS];
  logic [63:0]   mem_cnt [TABLE_SLOTS];
  logic [63:0]   mem_sum [TABLE_SLOTS];
  logic          rd_valid_r;
  logic [96:0]   rd_key_r;
  logic [63:0]   rd_cnt_r, rd_sum_r;
  logic          wr_en;
  logic [96:0]   wr_key;
  logic [63:0]   wr_cnt, wr_sum;
  logic [1:0]    hit_status_r;

  logic [96:0] key_w;
  logic [63:0] h0, h1, hfin, pp;
  logic [31:0] ma, mb;

  assign key_w = {in_r.caller_address, in_r.thread_id, in_r.alloc_kind};
  assign h0 = in_data.caller_address ^ ({32'd0, in_data.thread_id} << TID_SHIFT)
              ^ ({63'd0, in_data.alloc_kind} << KIND_SHIFT);
  assign h1 = h0 ^ (h0 >> HASH_SHIFT);
  assign hfin = prod_r ^ (prod_r >> HASH_SHIFT);

  // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
  always_comb begin
    unique case (mstep_r)
      2'd0: begin ma = hx_r[31:0];  mb = HASH_MUL[31:0];  end
      2'd1: begin ma = hx_r[31:0];  mb = HASH_MUL[63:32]; end
      default: begin ma = hx_r[63:32]; mb = HASH_MUL[31:0]; end
    endcase
  end
  assign pp = ma * mb;

  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_data = out_r;

  assign wr_en  = (state_r == S_WR);
  assign wr_key = key_w;
  assign wr_cnt = (hit_status_r == ST_UPDATED) ? rd_cnt_r + 64'd1 : 64'd1;
  assign wr_sum = (hit_status_r == ST_UPDATED) ? rd_sum_r + in_r.byte_count
                                                : in_r.byte_count;

  always_ff @(posedge clk) begin
    rd_valid_r <= mem_valid[slot_r];
    rd_key_r <= mem_key[slot_r];
    rd_cnt_r <= mem_cnt[slot_r];
    rd_sum_r <= mem_sum[slot_r];
    if (state_r == S_CLEAR) mem_valid[clr_r] <= 1'b0;
    else if (wr_en) mem_valid[slot_r] <= 1'b1;
    if (wr_en) begin
      mem_key[slot_r] <= wr_key;
      mem_cnt[slot_r] <= wr_cnt;
      mem_sum[slot_r] <= wr_sum;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(TABLE_SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = dis_r ? S_DIS : S_MUL;
      S_MUL:   if (mstep_r == 2'd2) state_nxt = S_HASH;
      S_HASH:  state_nxt = S_RD;
      S_RD:    state_nxt = S_CMP;
      S_CMP: begin
        if (!rd_valid_r || rd_key_r == key_w) state_nxt = S_WR;
        else if (probe_r == EFF_P) state_nxt = S_OVF;
        else state_nxt = S_RD;
      end
      S_WR:    state_nxt = S_OUT;
      S_OVF:   state_nxt = S_OUT;
      S_DIS:   state_nxt = S_OUT;
      S_OUT:   if (!ovalid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      dis_r <= 1'b0;
      ovalid_r <= 1'b0;
      gcalls_r <= '0;
      gbytes_r <= '0;
      ocalls_r <= '0;
      obytes_r <= '0;
      mstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) dis_r <= cfg_data;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + AW'(1);
        S_IDLE: if (in_valid) begin
          in_r <= in_data;
          hx_r <= h1;
          prod_r <= '0;
          mstep_r <= '0;
        end
        S_MUL: begin
          mstep_r <= mstep_r + 2'd1;
          unique case (mstep_r)
            2'd0: prod_r <= prod_r + pp;
            default: prod_r <= prod_r + {pp[31:0], 32'd0};
          endcase
        end
        S_HASH: begin
          slot_r <= hfin[AW-1:0];
          probe_r <= PW'(1);
          gcalls_r <= gcalls_r + 64'd1;
          gbytes_r <= gbytes_r + in_r.byte_count;
        end
        S_CMP: begin
          hit_status_r <= rd_valid_r ? ST_UPDATED : ST_CLAIMED;
          if (rd_valid_r && rd_key_r != key_w && probe_r != EFF_P) begin
            slot_r <= slot_r + AW'(1);
            probe_r <= probe_r + PW'(1);
          end
        end
        S_WR: begin
          out_r.status <= hit_status_r;
          out_r.slot_index <= 12'(slot_r);
          out_r.probes_taken <= 8'(probe_r);
          out_r.entry_calls <= wr_cnt;
          out_r.entry_bytes <= wr_sum;
          out_r.all_calls <= gcalls_r;
          out_r.all_bytes <= gbytes_r;
          out_r.spill_calls <= ocalls_r;
          out_r.spill_bytes <= obytes_r;
          ovalid_r <= 1'b1;
        end
        S_OVF: begin
          ocalls_r <= ocalls_r + 64'd1;
          obytes_r <= obytes_r + in_r.byte_count;
          out_r.status <= ST_OVERFLOW;
          out_r.slot_index <= '0;
          out_r.probes_taken <= 8'(EFF_P);
          out_r.entry_calls <= '0;
          out_r.entry_bytes <= '0;
          out_r.all_calls <= gcalls_r;
          out_r.all_bytes <= gbytes_r;
          out_r.spill_calls <= ocalls_r + 64'd1;
          out_r.spill_bytes <= obytes_r + in_r.byte_count;
          ovalid_r <= 1'b1;
        end
        S_DIS: begin
          out_r.status <= ST_IGNORED;
          out_r.slot_index <= '0;
          out_r.probes_taken <= '0;
          out_r.entry_calls <= '0;
          out_r.entry_bytes <= '0;
          out_r.all_calls <= gcalls_r;
          out_r.all_bytes <= gbytes_r;
          out_r.spill_calls <= ocalls_r;
          out_r.spill_bytes <= obytes_r;
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
